// ===== src/rbm_pkg.sv =====
// shared types, constants and codes for the rom/ram bank mapper with clock
package rbm_pkg;

    // default size of the cartridge ram in bytes
    localparam int RAM_BYTES_DEF = 32768;

    // configuration port data width, widest register
    localparam int CFG_W = 7;

    // configuration register indexes
    localparam logic [1:0] CFG_CLOCK_PRESENT = 2'd0;
    localparam logic [1:0] CFG_RAM_PRESENT   = 2'd1;
    localparam logic [1:0] CFG_ROM_MASK      = 2'd2;
    localparam logic [1:0] CFG_RAM_MASK      = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_ROM   = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;
    localparam logic [1:0] KIND_WRITE = 2'd3;

    // address regions, top three address bits
    localparam logic [2:0] RGN_ENABLE = 3'd0;
    localparam logic [2:0] RGN_ROMB   = 3'd1;
    localparam logic [2:0] RGN_RAMB   = 3'd2;
    localparam logic [2:0] RGN_LATCH  = 3'd3;
    localparam logic [2:0] RGN_EXT    = 3'd5;

    // clock register select codes
    localparam logic [3:0] RTC_SEC  = 4'h8;
    localparam logic [3:0] RTC_MIN  = 4'h9;
    localparam logic [3:0] RTC_HOUR = 4'hA;
    localparam logic [3:0] RTC_DAY  = 4'hB;
    localparam logic [3:0] RTC_CTRL = 4'hC;

    // enable pattern in the low nibble
    localparam logic [3:0] ENABLE_KEY = 4'hA;

    // reciprocals for exact division of a 30-bit value by 15 (shift 34) and by 3 (shift 32)
    localparam logic [30:0] RECIP_15 = 31'd1145324613;
    localparam logic [30:0] RECIP_3  = 31'd1431655766;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_ADVANCE,
        ST_FINISH
    } rbm_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
        logic div_start;
        logic div_step;
        logic advance;
        logic finish;
    } rbm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic adv_needed;
        logic div_done;
        logic out_free;
    } rbm_status_t;

endpackage

// ===== src/rbm_ctrl.sv =====
// controller state machine of the bank mapper
module rbm_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rbm_pkg::rbm_status_t st,
    output rbm_pkg::rbm_cmd_t    cmd
);
    import rbm_pkg::*;

    rbm_state_t state_reg;
    rbm_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.exec = 1'b1;
                if (st.adv_needed)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a waiting result holds the controller in finish
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !st.out_free) |=> state_reg == ST_FINISH)
        else $error("finish left while output busy");

    // the divider only runs after a decode that asked for it
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_DIV) |-> $past(state_reg == ST_DECODE && st.adv_needed))
        else $error("divider entered without request");

endmodule

// ===== src/rbm_datapath.sv =====
// datapath of the bank mapper: control registers, clock, ram and divider
module rbm_datapath
#(
    parameter int RAM_BYTES = rbm_pkg::RAM_BYTES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [rbm_pkg::CFG_W-1:0] cfg_data,
    input  logic                     req_type,
    input  logic [15:0]              bus_address,
    input  logic [7:0]               write_byte,
    input  logic signed [31:0]       now_seconds,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               result_kind,
    output logic [7:0]               read_byte,
    output logic [20:0]              rom_address,
    input  rbm_pkg::rbm_cmd_t        cmd,
    output rbm_pkg::rbm_status_t     st
);
    import rbm_pkg::*;

    localparam int AW = $clog2(RAM_BYTES);
    localparam logic [15:0] RAM_SIZE = 16'(RAM_BYTES);
    localparam logic [AW-1:0] CLR_END = AW'(RAM_BYTES - 1);

    // configuration
    logic       clock_present_reg;
    logic       ram_present_reg;
    logic [6:0] rom_mask_reg;
    logic [1:0] ram_mask_reg;

    // captured request
    logic        wr_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [31:0] now_reg;

    // mapper state
    logic [6:0] rom_bank_reg;
    logic [1:0] ram_bank_reg;
    logic       clock_mode_reg;
    logic       ram_enable_reg;
    logic       clock_enable_reg;
    logic [3:0] clock_select_reg;
    logic [7:0] live_sec_reg;
    logic [7:0] live_min_reg;
    logic [7:0] live_hour_reg;
    logic [8:0] live_days_reg;
    logic [7:0] live_ctrl_reg;
    logic [7:0] latched_reg [5];
    logic       latch_prev_reg;
    logic       latch_go_reg;
    logic [31:0] last_time_reg;
    logic [31:0] time_cache_reg;

    // ram and clearing sweep
    logic [7:0]    mem [RAM_BYTES];
    logic [7:0]    mem_rd_reg;
    logic [AW-1:0] clr_cnt_reg;

    // constant divider: product registered first, then quotient and remainder from it
    logic [31:0] div_q_reg;
    logic [60:0] div_p_reg;
    logic        div_ph_reg;
    logic [1:0]  div_stage_reg;
    logic [5:0]  rem_sec_reg;
    logic [5:0]  rem_min_reg;
    logic [4:0]  rem_hour_reg;

    // output register
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic [20:0] rom_addr_reg;

    logic [2:0]    region;
    logic          clock_on;
    logic [15:0]   idx_wide;
    logic [AW-1:0] ram_idx;
    logic          latch_trig;
    logic signed [32:0] diff;
    logic          diff_pos;
    logic [29:0]   mul_a;
    logic [30:0]   mul_m;
    logic [31:0]   q_div;
    logic [5:0]    r_sec;
    logic [4:0]    q24_lo;
    logic [4:0]    r_day;
    logic [8:0]    s9, m9, h9, s_fin, m_fin, h_fin;
    logic          c_sec, c_min, c_hour;
    logic [16:0]   d17;
    logic [7:0]    ctrl_adv;
    logic [1:0]    kind_c;
    logic [7:0]    byte_c;
    logic [20:0]   rom_c;
    logic          ram_wr;
    logic          clk_wr;
    logic [3:0]    sel_off;

    assign region   = addr_reg[15:13];
    assign clock_on = clock_present_reg & clock_enable_reg;

    // ram index wraps modulo the ram size
    always_comb
    begin
        idx_wide = {1'b0, ram_bank_reg, addr_reg[12:0]};
        for (int k = 0; k < 3; k++)
        begin
            if (idx_wide >= RAM_SIZE)
            begin
                idx_wide = idx_wide - RAM_SIZE;
            end
        end
        ram_idx = idx_wide[AW-1:0];
    end

    // latch edge and elapsed time
    assign latch_trig = wr_reg && region == RGN_LATCH && clock_present_reg
                        && !latch_prev_reg && data_reg == 8'd1;
    assign diff       = {now_reg[31], now_reg} - {last_time_reg[31], last_time_reg};
    assign diff_pos   = !diff[32] && diff != 33'sd0;

    assign ram_wr = wr_reg && region == RGN_EXT && !clock_mode_reg && ram_enable_reg;
    assign clk_wr = wr_reg && region == RGN_EXT && clock_mode_reg && clock_on;

    // divide by 60 as (x / 4) / 15 and by 24 as (x / 8) / 3, remainders from the low bits
    always_comb
    begin
        if (div_stage_reg == 2'd2)
        begin
            mul_a = {1'b0, div_q_reg[31:3]};
            mul_m = RECIP_3;
            q_div = {3'b0, div_p_reg[60:32]};
        end
        else
        begin
            mul_a = div_q_reg[31:2];
            mul_m = RECIP_15;
            q_div = {5'b0, div_p_reg[60:34]};
        end
        r_sec  = div_q_reg[5:0] + {q_div[3:0], 2'b00};
        q24_lo = {q_div[1:0], 3'b000} + {q_div[0], 4'b0000};
        r_day  = div_q_reg[4:0] - q24_lo;
    end

    // clock advance with one carry per field
    always_comb
    begin
        s9     = {1'b0, live_sec_reg} + {3'b0, rem_sec_reg};
        c_sec  = s9 > 9'd59;
        s_fin  = c_sec ? s9 - 9'd60 : s9;
        m9     = {1'b0, live_min_reg} + {3'b0, rem_min_reg} + {8'b0, c_sec};
        c_min  = m9 > 9'd59;
        m_fin  = c_min ? m9 - 9'd60 : m9;
        h9     = {1'b0, live_hour_reg} + {4'b0, rem_hour_reg} + {8'b0, c_min};
        c_hour = h9 > 9'd23;
        h_fin  = c_hour ? h9 - 9'd24 : h9;
        d17    = {8'b0, live_days_reg} + {16'b0, c_hour} + div_q_reg[16:0];
        ctrl_adv = live_ctrl_reg;
        if (|d17[16:9])
        begin
            ctrl_adv = ctrl_adv | 8'h80;
        end
        if (d17[8])
        begin
            ctrl_adv = ctrl_adv | 8'h01;
        end
    end

    // result of the captured request
    always_comb
    begin
        kind_c  = KIND_NONE;
        byte_c  = 8'd0;
        rom_c   = 21'd0;
        sel_off = clock_select_reg - RTC_SEC;
        if (!wr_reg)
        begin
            if (region == RGN_RAMB || region == RGN_LATCH)
            begin
                kind_c = KIND_ROM;
                rom_c  = {rom_bank_reg, addr_reg[13:0]};
            end
            else if (region == RGN_EXT)
            begin
                kind_c = KIND_READ;
                byte_c = 8'hFF;
                if (!clock_mode_reg)
                begin
                    if (ram_enable_reg)
                    begin
                        byte_c = mem_rd_reg;
                    end
                end
                else if (clock_on && clock_select_reg >= RTC_SEC
                         && clock_select_reg <= RTC_CTRL)
                begin
                    byte_c = latched_reg[sel_off[2:0]];
                end
            end
        end
        else if (region == RGN_ENABLE || region == RGN_ROMB || region == RGN_RAMB
                 || region == RGN_LATCH || region == RGN_EXT)
        begin
            kind_c = KIND_WRITE;
        end
    end

    // status to the controller
    assign st.clr_last   = clr_cnt_reg == CLR_END;
    assign st.adv_needed = latch_trig && time_cache_reg != now_reg && diff_pos;
    assign st.div_done   = div_stage_reg == 2'd2 && div_ph_reg;
    assign st.out_free   = !out_valid_reg || !out_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_present_reg <= 1'b1;
            ram_present_reg   <= 1'b1;
            rom_mask_reg      <= 7'h7F;
            ram_mask_reg      <= 2'd3;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CLOCK_PRESENT: clock_present_reg <= cfg_data[0];
                CFG_RAM_PRESENT:   ram_present_reg   <= cfg_data[0];
                CFG_ROM_MASK:      rom_mask_reg      <= cfg_data[6:0];
                CFG_RAM_MASK:      ram_mask_reg      <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            wr_reg   <= req_type;
            addr_reg <= bus_address;
            data_reg <= write_byte;
            now_reg  <= now_seconds;
        end
    end

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // ram, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_cnt_reg] <= 8'hFF;
        end
        else if (cmd.exec && ram_wr)
        begin
            mem[ram_idx] <= data_reg;
        end
        mem_rd_reg <= mem[ram_idx];
    end

    // mapper and clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg     <= 7'd1;
            ram_bank_reg     <= 2'd0;
            clock_mode_reg   <= 1'b0;
            ram_enable_reg   <= 1'b0;
            clock_enable_reg <= 1'b0;
            clock_select_reg <= 4'd0;
            live_sec_reg     <= 8'd0;
            live_min_reg     <= 8'd0;
            live_hour_reg    <= 8'd0;
            live_days_reg    <= 9'd0;
            live_ctrl_reg    <= 8'd0;
            for (int i = 0; i < 5; i++)
            begin
                latched_reg[i] <= 8'd0;
            end
            latch_prev_reg   <= 1'b0;
            latch_go_reg     <= 1'b0;
            last_time_reg    <= 32'hFFFF_FFFF;
            time_cache_reg   <= 32'd0;
        end
        else
        begin
            if (cmd.exec)
            begin
                latch_go_reg <= latch_trig;
                if (wr_reg)
                begin
                    case (region)
                        RGN_ENABLE:
                        begin
                            if (ram_present_reg)
                            begin
                                ram_enable_reg <= data_reg[3:0] == ENABLE_KEY;
                            end
                            clock_enable_reg <= data_reg[3:0] == ENABLE_KEY;
                        end
                        RGN_ROMB:
                        begin
                            if (data_reg[6:0] == 7'd0)
                            begin
                                rom_bank_reg <= 7'd1 & rom_mask_reg;
                            end
                            else
                            begin
                                rom_bank_reg <= data_reg[6:0] & rom_mask_reg;
                            end
                        end
                        RGN_RAMB:
                        begin
                            if (data_reg >= {4'd0, RTC_SEC} && data_reg <= {4'd0, RTC_CTRL})
                            begin
                                if (clock_on)
                                begin
                                    clock_select_reg <= data_reg[3:0];
                                    clock_mode_reg   <= 1'b1;
                                end
                            end
                            else if (data_reg <= 8'd3)
                            begin
                                ram_bank_reg   <= data_reg[1:0] & ram_mask_reg;
                                clock_mode_reg <= 1'b0;
                            end
                        end
                        RGN_LATCH:
                        begin
                            if (clock_present_reg && data_reg <= 8'd1)
                            begin
                                latch_prev_reg <= data_reg[0];
                            end
                            if (latch_trig && time_cache_reg != now_reg)
                            begin
                                time_cache_reg <= now_reg;
                                last_time_reg  <= now_reg;
                            end
                        end
                        RGN_EXT:
                        begin
                            if (clk_wr)
                            begin
                                last_time_reg <= now_reg;
                                case (clock_select_reg)
                                    RTC_SEC:  live_sec_reg  <= data_reg;
                                    RTC_MIN:  live_min_reg  <= data_reg;
                                    RTC_HOUR: live_hour_reg <= data_reg;
                                    RTC_DAY:  live_days_reg <= {1'b0, data_reg};
                                    RTC_CTRL: live_ctrl_reg <= data_reg
                                                  | (live_ctrl_reg & 8'h80);
                                    default:  ;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (cmd.advance)
            begin
                live_sec_reg  <= s_fin[7:0];
                live_min_reg  <= m_fin[7:0];
                live_hour_reg <= h_fin[7:0];
                live_days_reg <= d17[8:0];
                live_ctrl_reg <= ctrl_adv;
            end
            if (cmd.finish && latch_go_reg)
            begin
                latched_reg[0] <= live_sec_reg;
                latched_reg[1] <= live_min_reg;
                latched_reg[2] <= live_hour_reg;
                latched_reg[3] <= live_days_reg[7:0];
                latched_reg[4] <= live_ctrl_reg;
            end
        end
    end

    // elapsed time divided by 60, 60 and 24 in turn
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_ph_reg    <= 1'b0;
            div_stage_reg <= 2'd0;
        end
        else if (cmd.div_start)
        begin
            div_ph_reg    <= 1'b0;
            div_stage_reg <= 2'd0;
        end
        else if (cmd.div_step)
        begin
            div_ph_reg <= !div_ph_reg;
            if (div_ph_reg && div_stage_reg != 2'd2)
            begin
                div_stage_reg <= div_stage_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_q_reg <= diff[31:0];
        end
        else if (cmd.div_step)
        begin
            if (!div_ph_reg)
            begin
                div_p_reg <= mul_a * mul_m;
            end
            else
            begin
                div_q_reg <= q_div;
                case (div_stage_reg)
                    2'd0:    rem_sec_reg  <= r_sec;
                    2'd1:    rem_min_reg  <= r_sec;
                    default: rem_hour_reg <= r_day;
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            kind_reg     <= kind_c;
            byte_reg     <= byte_c;
            rom_addr_reg <= rom_c;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign read_byte   = byte_reg;
    assign rom_address = rom_addr_reg;

    // clock mode always points at a real clock register
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        clock_mode_reg |-> (clock_select_reg >= RTC_SEC && clock_select_reg <= RTC_CTRL))
        else $error("clock selected with bad register");

    // rom address only on rom window reads
    a_rom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_ROM) |-> rom_addr_reg == 21'd0)
        else $error("stray rom address");

    // byte only on window reads
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_READ) |-> byte_reg == 8'd0)
        else $error("stray read byte");

endmodule

// ===== src/rom_ram_bank_mapper_with_rtc_unit.sv =====
// Bank mapper with clock: an accepted request is decoded and executed, then its result is
// registered in the finish state once the output register is free.
// A clock latch that must advance the clock first divides the elapsed seconds by 60, 60
// and 24 by reciprocal multiplication, a product then a quotient step each, then one update.
// One request is in flight at a time; the next is accepted once the result is registered.
// After reset the ram is swept to 0xFF, one byte a cycle over all RAM_BYTES bytes,
// during which no request is accepted; configuration writes are taken throughout.
module rom_ram_bank_mapper_with_rtc_unit
#(
    parameter int RAM_BYTES = rbm_pkg::RAM_BYTES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [rbm_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      req_type,
    input  logic [15:0]               bus_address,
    input  logic [7:0]                write_byte,
    input  logic signed [31:0]        now_seconds,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                result_kind,
    output logic [7:0]                read_byte,
    output logic [20:0]               rom_address
);
    import rbm_pkg::*;

    rbm_cmd_t    cmd;
    rbm_status_t st;

    // controller
    rbm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    rbm_datapath #(.RAM_BYTES(RAM_BYTES)) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .bus_address (bus_address),
        .write_byte  (write_byte),
        .now_seconds (now_seconds),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .read_byte   (read_byte),
        .rom_address (rom_address),
        .cmd         (cmd),
        .st          (st)
    );

    // an accepted request blocks the input until its result is registered
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open while request in flight");

endmodule

// ===== test/tb_top.sv =====
// testbench for the rom/ram bank mapper with clock: own-model scoreboard, directed and random traffic
`timescale 1ns / 100ps

module tb_top;
    import rbm_pkg::*;

    // request types
    localparam bit REQ_READ  = 1'b0;
    localparam bit REQ_WRITE = 1'b1;
    localparam int RAM_SIZE  = 32768;
    localparam int STALL_LIMIT = 200000;

    // one expected result
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  rbyte;
        logic [20:0] raddr;
    } bus_result_t;

    // mapper model and store of pending results
    class mapper_board;
        bus_result_t pending[$];
        int errors;
        bit clock_present, ram_present;
        bit [6:0] rom_mask;
        bit [1:0] ram_mask;
        bit [7:0] ram_mem[RAM_SIZE];
        bit [6:0] rom_bank;
        bit [1:0] ram_bank;
        bit clock_mode, ram_enable, clock_enable, latch_prev;
        bit [3:0] clock_select;
        bit [7:0] sec, mins, hrs, ctrl;
        bit [8:0] days;
        bit [7:0] latched[5];
        bit [31:0] last_time, time_cache;

        function new();
            clock_present = 1; ram_present = 1; rom_mask = 7'h7F; ram_mask = 2'd3;
            foreach (ram_mem[i]) ram_mem[i] = 8'hFF;
            rom_bank = 1; ram_bank = 0; clock_mode = 0;
            ram_enable = 0; clock_enable = 0; clock_select = 0; latch_prev = 0;
            sec = 0; mins = 0; hrs = 0; days = 0; ctrl = 0;
            foreach (latched[i]) latched[i] = 0;
            last_time = 32'hFFFF_FFFF; time_cache = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] val);
            case (idx)
                CFG_CLOCK_PRESENT: clock_present = val[0];
                CFG_RAM_PRESENT:   ram_present = val[0];
                CFG_ROM_MASK:      rom_mask = val;
                CFG_RAM_MASK:      ram_mask = val[1:0];
            endcase
        endfunction

        function int ram_slot(bit [15:0] a);
            return ((int'(a) - 'hA000) + int'(ram_bank) * 'h2000) % RAM_SIZE;
        endfunction

        // bring the live clock up to the given time
        function void advance_clock(bit [31:0] now);
            longint diff, rest;
            int s, m, h, d;
            if (time_cache == now)
                return;
            time_cache = now;
            diff = longint'($signed(now)) - longint'($signed(last_time));
            if (diff > 0)
            begin
                rest = diff;
                s = sec; m = mins; h = hrs; d = days;
                s += int'(rest % 60);
                if (s > 59) begin s -= 60; m++; end
                rest /= 60;
                m += int'(rest % 60);
                if (m > 59) begin m -= 60; h++; end
                rest /= 60;
                h += int'(rest % 24);
                if (h > 23) begin h -= 24; d++; end
                rest /= 24;
                d += int'(rest);
                if (d > 511)
                begin
                    d %= 512;
                    ctrl[7] = 1'b1;
                end
                if (d > 255)
                    ctrl[0] = 1'b1;
                sec = s[7:0]; mins = m[7:0]; hrs = h[7:0]; days = d[8:0];
            end
            last_time = now;
        endfunction

        // work out the result of an accepted request
        function void note_request(bit rt, bit [15:0] a, bit [7:0] d, bit [31:0] now);
            bus_result_t r;
            bit [2:0] rgn;
            bit clk_on;
            bit [6:0] b;
            rgn = a[15:13];
            clk_on = clock_present && clock_enable;
            r.kind = KIND_NONE; r.rbyte = 0; r.raddr = 0;
            if (rt == REQ_READ)
            begin
                if (rgn == RGN_RAMB || rgn == RGN_LATCH)
                begin
                    r.kind = KIND_ROM;
                    r.raddr = 21'(a) - 21'h4000 + {rom_bank, 14'd0};
                end
                else if (rgn == RGN_EXT)
                begin
                    r.kind = KIND_READ;
                    r.rbyte = 8'hFF;
                    if (!clock_mode)
                    begin
                        if (ram_enable) r.rbyte = ram_mem[ram_slot(a)];
                    end
                    else if (clk_on && clock_select >= RTC_SEC && clock_select <= RTC_CTRL)
                        r.rbyte = latched[clock_select - RTC_SEC];
                end
            end
            else
            begin
                case (rgn)
                    RGN_ENABLE:
                    begin
                        r.kind = KIND_WRITE;
                        if (ram_present) ram_enable = (d[3:0] == ENABLE_KEY);
                        clock_enable = (d[3:0] == ENABLE_KEY);
                    end
                    RGN_ROMB:
                    begin
                        r.kind = KIND_WRITE;
                        b = d[6:0];
                        if (b == 0) b = 1;
                        rom_bank = b & rom_mask;
                    end
                    RGN_RAMB:
                    begin
                        r.kind = KIND_WRITE;
                        if (d >= 8'(RTC_SEC) && d <= 8'(RTC_CTRL))
                        begin
                            if (clk_on)
                            begin
                                clock_select = d[3:0];
                                clock_mode = 1;
                            end
                        end
                        else if (d <= 8'd3)
                        begin
                            ram_bank = d[1:0] & ram_mask;
                            clock_mode = 0;
                        end
                    end
                    RGN_LATCH:
                    begin
                        r.kind = KIND_WRITE;
                        if (clock_present)
                        begin
                            if (!latch_prev && d == 8'd1)
                            begin
                                advance_clock(now);
                                latched[0] = sec; latched[1] = mins; latched[2] = hrs;
                                latched[3] = days[7:0]; latched[4] = ctrl;
                            end
                            if (d <= 8'd1) latch_prev = d[0];
                        end
                    end
                    RGN_EXT:
                    begin
                        r.kind = KIND_WRITE;
                        if (!clock_mode)
                        begin
                            if (ram_enable) ram_mem[ram_slot(a)] = d;
                        end
                        else if (clk_on)
                        begin
                            last_time = now;
                            case (clock_select)
                                RTC_SEC:  sec = d;
                                RTC_MIN:  mins = d;
                                RTC_HOUR: hrs = d;
                                RTC_DAY:  days = {1'b0, d};
                                RTC_CTRL: ctrl = ctrl[7] ? (d | 8'h80) : d;
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        // compare one result with the oldest expectation
        task check_result(logic [1:0] k, logic [7:0] rb, logic [20:0] ra);
            bus_result_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d", k));
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind)
                report($sformatf("result_kind %0d, want %0d", k, e.kind));
            if (rb !== e.rbyte)
                report($sformatf("read_byte %02h, want %02h", rb, e.rbyte));
            if (ra !== e.raddr)
                report($sformatf("rom_address %06h, want %06h", ra, e.raddr));
        endtask
    endclass

    logic clk, rst_n;
    logic cfg_write;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic req_type;
    logic [15:0] bus_address;
    logic [7:0] write_byte;
    logic signed [31:0] now_seconds;
    logic [1:0] result_kind;
    logic [7:0] read_byte;
    logic [20:0] rom_address;

    mapper_board board;
    bit no_idle;
    int hold_req;
    int idle_cycles;
    bit [31:0] wall;

    rom_ram_bank_mapper_with_rtc_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .bus_address(bus_address),
        .write_byte(write_byte), .now_seconds(now_seconds),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .read_byte(read_byte), .rom_address(rom_address)
    );

    // clock
    initial clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // result side with random and long stalls
    int stall_left, long_left;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                board.check_result(result_kind, read_byte, rom_address);
                stall_left = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (hold_req > 0)
            begin
                long_left = hold_req;
                hold_req = 0;
            end
            if (long_left > 0)
            begin
                long_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // offer one request and wait until it is taken
    task send_request(bit rt, bit [15:0] a, bit [7:0] d, bit [31:0] now);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        bus_address <= a;
        write_byte <= d;
        now_seconds <= now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_request(rt, a, d, now);
    endtask

    // stop offering until every result is back, then let the block settle
    task drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [6:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task set_config(bit cp, bit rp, bit [6:0] rm, bit [1:0] bm);
        write_reg(CFG_CLOCK_PRESENT, {6'd0, cp});
        write_reg(CFG_RAM_PRESENT, {6'd0, rp});
        write_reg(CFG_ROM_MASK, rm);
        write_reg(CFG_RAM_MASK, {5'd0, bm});
    endtask

    // step the wall time, mostly small, sometimes far, back or anywhere
    function bit [31:0] next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) wall += $urandom_range(0, 3);
        else if (r < 85) wall += $urandom_range(0, 100000);
        else if (r < 93) wall += $urandom_range(0, 86400 * 600);
        else if (r < 97) wall -= $urandom_range(0, 5000);
        else wall = $urandom;
        return wall;
    endfunction

    // one random request, mostly well-formed mapper traffic
    task random_request;
        int r, s;
        bit rt;
        bit [15:0] a;
        bit [7:0] d;
        r = $urandom_range(0, 99);
        d = $urandom_range(0, 255);
        rt = REQ_WRITE;
        if (r < 10)
        begin
            a = $urandom_range(16'h0000, 16'h1FFF);
            if ($urandom_range(0, 4) != 0) d[3:0] = ENABLE_KEY;
        end
        else if (r < 18)
            a = $urandom_range(16'h2000, 16'h3FFF);
        else if (r < 30)
        begin
            a = $urandom_range(16'h4000, 16'h5FFF);
            s = $urandom_range(0, 2);
            if (s == 0) d = $urandom_range(0, 3);
            else if (s == 1) d = $urandom_range(RTC_SEC, RTC_CTRL);
        end
        else if (r < 42)
        begin
            a = $urandom_range(16'h6000, 16'h7FFF);
            if ($urandom_range(0, 5) != 0) d = $urandom_range(0, 1);
        end
        else if (r < 62)
        begin
            rt = REQ_READ;
            a = $urandom_range(16'hA000, 16'hBFFF);
        end
        else if (r < 77)
            a = $urandom_range(16'hA000, 16'hBFFF);
        else if (r < 87)
        begin
            rt = REQ_READ;
            a = $urandom_range(16'h4000, 16'h7FFF);
        end
        else
        begin
            rt = $urandom_range(0, 1);
            a = $urandom_range(0, 65535);
        end
        send_request(rt, a, d, next_time());
    endtask

    task random_run(int n);
        repeat (n) random_request();
    endtask

    initial
    begin
        board = new();
        rst_n = 0;
        cfg_write = 0; cfg_index = 0; cfg_data = 0;
        in_valid = 0; req_type = 0; bus_address = 0; write_byte = 0; now_seconds = 0;
        out_stall = 0;
        no_idle = 0; hold_req = 0; idle_cycles = 0;
        stall_left = 0; long_left = 0;
        wall = 1000;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        set_config(1, 1, 7'h7F, 2'd3);

        // directed: disabled window, rom window edges, unhandled ranges
        send_request(REQ_READ, 16'hA000, 8'h00, 32'd0);
        send_request(REQ_READ, 16'h4000, 8'h00, 32'd0);
        send_request(REQ_READ, 16'h7FFF, 8'h00, 32'd0);
        send_request(REQ_READ, 16'h0000, 8'h00, 32'd0);
        send_request(REQ_WRITE, 16'hFFFF, 8'hFF, 32'd0);
        // rom bank zero and top bit masked off
        send_request(REQ_WRITE, 16'h2000, 8'h00, 32'd0);
        send_request(REQ_WRITE, 16'h3FFF, 8'h80, 32'd0);
        send_request(REQ_WRITE, 16'h2000, 8'h7F, 32'd0);
        send_request(REQ_READ, 16'h6123, 8'h00, 32'd0);
        // enable ram, write and read two banks
        send_request(REQ_WRITE, 16'h0000, 8'h0A, 32'd0);
        send_request(REQ_WRITE, 16'hA000, 8'h5A, 32'd0);
        send_request(REQ_READ, 16'hA000, 8'h00, 32'd0);
        send_request(REQ_WRITE, 16'h4000, 8'h03, 32'd0);
        send_request(REQ_WRITE, 16'hBFFF, 8'hA5, 32'd0);
        send_request(REQ_READ, 16'hBFFF, 8'h00, 32'd0);
        // clock: set day near overflow, then latch across a huge jump
        send_request(REQ_WRITE, 16'h4000, 8'h0B, 32'h7FFF_0000);
        send_request(REQ_WRITE, 16'hA000, 8'hFF, 32'h8000_0000);
        send_request(REQ_WRITE, 16'h6000, 8'h00, 32'h8000_0000);
        send_request(REQ_WRITE, 16'h6000, 8'h01, 32'h7FFF_FFFF);
        send_request(REQ_READ, 16'hA000, 8'h00, 32'h7FFF_FFFF);
        send_request(REQ_WRITE, 16'h4000, 8'h0C, 32'h7FFF_FFFF);
        send_request(REQ_WRITE, 16'hA000, 8'h01, 32'h7FFF_FFFF);
        send_request(REQ_READ, 16'hA000, 8'h00, 32'h7FFF_FFFF);
        send_request(REQ_WRITE, 16'h0000, 8'h00, 32'h7FFF_FFFF);
        send_request(REQ_READ, 16'hA000, 8'h00, 32'h7FFF_FFFF);
        drain();

        // random phases over several settings
        random_run(150);
        hold_req = 300;
        random_run(40);
        drain();
        set_config(0, 1, 7'h00, 2'd0);
        random_run(180);
        drain();
        set_config(1, 0, 7'h05, 2'd1);
        no_idle = 1;
        random_run(120);
        no_idle = 0;
        random_run(60);
        drain();
        set_config(0, 0, 7'h7F, 2'd2);
        random_run(180);
        drain();
        set_config(1, 1, 7'h1F, 2'd3);
        random_run(220);
        drain();
        set_config(1, 1, 7'h7F, 2'd3);
        random_run(200);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
        begin
            if (board.pending.size() != 0)
                board.report($sformatf("%0d results never arrived", board.pending.size()));
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/rbm_pkg.sv
src/rbm_ctrl.sv
src/rbm_datapath.sv
src/rom_ram_bank_mapper_with_rtc_unit.sv
test/tb_top.sv
